// ===== design/rcrs_pkg.sv =====
// ----------------------------------------------------------------------------
// rcrs_pkg
// types, command codes and the exp2 constant table of the circle raster store
// ----------------------------------------------------------------------------
package rcrs_pkg;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_SOLID = 2'd1,
		OP_GRAD  = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		S_INIT,
		S_IDLE,
		S_CLR_RD,
		S_CLR_WR,
		S_RD,
		S_RD_WAIT,
		S_FIN,
		S_G0,
		S_G1,
		S_G2,
		S_G3,
		S_G4,
		S_PIX,
		S_GLOAD,
		S_SQRT,
		S_DIV,
		S_LOG_MUL,
		S_LOG_UPD,
		S_EXP_MUL,
		S_EXP_SPLIT,
		S_EXP_CHK,
		S_EXP_ACC,
		S_BL_MUL,
		S_BL_UPD,
		S_WR
	} state_t;

	localparam logic [16:0] ALPHA_ONE = 17'h10000;
	localparam logic [30:0] ACC_ONE   = 31'h40000000;

	typedef logic [29:0] ck_tab_t [17];

	function automatic logic [63:0] isqrt_c(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bitv;
		rem = v;
		res = '0;
		for (int i = 31; i >= 0; i--) begin
			bitv = 64'd1 << (2 * i);
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
		end
		return res;
	endfunction

	// c_k = 2^30 * 2^(-2^-k), each from the one before
	function automatic ck_tab_t make_ck();
		ck_tab_t t;
		logic [63:0] c;
		t[0] = '0;
		c = isqrt_c(64'd1 << 59);
		t[1] = c[29:0];
		for (int k = 2; k <= 16; k++) begin
			c = isqrt_c({4'b0, t[k-1], 30'b0});
			t[k] = c[29:0];
		end
		return t;
	endfunction

	localparam ck_tab_t CK = make_ck();

endpackage

// ===== design/rcrs_if.sv =====
// ----------------------------------------------------------------------------
// rcrs_cmd_if / rcrs_rsp_if
// command and result channels of the circle raster store
// ----------------------------------------------------------------------------
interface rcrs_cmd_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  operation;
	logic signed [10:0] pos_x;
	logic signed [10:0] pos_y;
	logic        [7:0]  radius;
	logic        [7:0]  red_in;
	logic        [7:0]  green_in;
	logic        [7:0]  blue_in;
	logic        [7:0]  alpha_in;
	logic        [1:0]  channel;
	logic        [7:0]  clear_value;
	logic        [9:0]  falloff_ratio;
	logic        [11:0] falloff_power;

	modport source (output valid, operation, pos_x, pos_y, radius, red_in, green_in,
		blue_in, alpha_in, channel, clear_value, falloff_ratio, falloff_power,
		input ready);
	modport sink (input valid, operation, pos_x, pos_y, radius, red_in, green_in,
		blue_in, alpha_in, channel, clear_value, falloff_ratio, falloff_power,
		output ready);
endinterface

interface rcrs_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic [7:0] alpha_out;
	logic       read_valid;

	modport source (output valid, red_out, green_out, blue_out, alpha_out, read_valid,
		input ready);
	modport sink (input valid, red_out, green_out, blue_out, alpha_out, read_valid,
		output ready);
endinterface

// ===== design/rcrs_ram.sv =====
// ----------------------------------------------------------------------------
// rcrs_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rcrs_ram #(
	parameter int DATA_W = 32,
	parameter int DEPTH  = 65536
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [DATA_W-1:0]                      wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [DATA_W-1:0]                      rdata
);
	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== design/rgba_circle_raster_store.sv =====
// ----------------------------------------------------------------------------
// rgba_circle_raster_store
// rgba8 frame store with clear, solid circle, soft circle and pixel read
// ----------------------------------------------------------------------------
// Commands come in on cmd, one item each; every command gives exactly one
// result item on rsp (pixel bytes and read_valid for a read, zeros otherwise).
// One command is worked on at a time: cmd.ready is high only while idle.
// After reset the store is swept to zero, and no command is taken meanwhile.
// Work per command, all through the one store ram and one 32x32 multiplier:
//   clear channel: a read and a write per pixel
//   read pixel: one store read when the position lies inside the store
//   solid circle: setup, then each of the (2r+1)^2 candidate pixels in turn
//   soft circle: as solid, plus for each pixel inside the circle a store read
//     and 4 lane blends, and for a pixel on the soft edge also 17 square root
//     steps, 24 divide steps, 16 log squarings, 16 exp steps plus up to
//     16 exp products
// A finished result waits in an output register; a stalled receiver holds the
// block only at the end of the next command.
// ----------------------------------------------------------------------------
module rgba_circle_raster_store #(
	parameter int WIDTH      = 256,
	parameter int HEIGHT     = 256,
	parameter int MAX_RADIUS = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	rcrs_cmd_if.sink   cmd,
	rcrs_rsp_if.source rsp
);
	localparam int DEPTH = WIDTH * HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	rcrs_pkg::state_t state_q, state_d;

	logic [1:0]         op_q;
	logic signed [10:0] cx_q, cy_q;
	logic [7:0]         r_q;
	logic [31:0]        col_q;
	logic [1:0]         lane_q;
	logic [7:0]         cval_q;
	logic [9:0]         ratio_q;
	logic [11:0]        power_q;

	logic [16:0]        r2_q;
	logic [9:0]         falloff_q;
	logic [20:0]        inner2_q;
	logic signed [9:0]  dx_q, dy_q;
	logic [17:0]        dy2_q, d2_q;
	logic [AW-1:0]      cnt_q, pa_q;

	logic [19:0]        rem_q;
	logic [16:0]        root_q;
	logic [33:0]        sv_q;
	logic [4:0]         it_q;
	logic [23:0]        dvd_q, quo_q;
	logic [9:0]         drem_q;
	logic [30:0]        x_q;
	logic [15:0]        f_q;
	logic [3:0]         m_q;
	logic [4:0]         n_q;
	logic [30:0]        acc_q;
	logic [16:0]        alpha_q;
	logic [31:0]        wd_q;
	logic [1:0]         bl_q;

	logic [31:0]        res_pix_q;
	logic               res_rv_q;
	logic               rsp_valid_q;
	logic [31:0]        rsp_pix_q;
	logic               rsp_rv_q;

	logic [31:0]        mul_a, mul_b;
	logic [63:0]        mul_p_q;

	logic               ram_we, ram_re;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic [31:0]        ram_wdata, ram_rdata;

	rcrs_ram #(.DATA_W(32), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// datapath helpers
	logic               accept, fin_go;
	logic signed [9:0]  r_s;
	logic signed [12:0] nx, ny, rx, ry;
	logic               in_circ, in_bnd, rd_in, last_pix, row_end;
	logic [20:0]        pix_lin, rd_lin;
	logic [18:0]        dxstep, dystep;
	logic [17:0]        d2_n, dy2_n;
	logic [19:0]        rem_sh, rem_n;
	logic [18:0]        trial;
	logic               sq_ge;
	logic [16:0]        root_n;
	logic [15:0]        num;
	logic [10:0]        dr_sh;
	logic               d_ge;
	logic [9:0]         drem_n;
	logic [23:0]        quo_n;
	logic [3:0]         msb;
	logic [31:0]        y_sq;
	logic [20:0]        lval;
	logic [30:0]        acc_cur;
	logic [16:0]        alpha_fin;
	logic signed [10:0] inner;
	logic [9:0]         inner_abs;
	logic [31:0]        clr_word;
	logic [7:0]         nw;
	logic [7:0]         r_sat;
	logic [9:0]         fo;

	assign accept = cmd.valid && cmd.ready;
	assign fin_go = (state_q == rcrs_pkg::S_FIN) && (!rsp_valid_q || rsp.ready);
	assign r_s    = $signed({2'b00, r_q});
	assign nx     = 13'(cx_q) + 13'(dx_q);
	assign ny     = 13'(cy_q) + 13'(dy_q);
	assign rx     = 13'(cx_q);
	assign ry     = 13'(cy_q);
	assign in_circ = {1'b0, d2_q} <= {2'b00, r2_q};
	assign in_bnd = (nx >= 0) && (nx < $signed(13'(WIDTH)))
		&& (ny >= 0) && (ny < $signed(13'(HEIGHT)));
	assign rd_in  = (rx >= 0) && (rx < $signed(13'(WIDTH)))
		&& (ry >= 0) && (ry < $signed(13'(HEIGHT)));
	assign pix_lin = 21'(ny[9:0]) * 21'(WIDTH) + 21'(nx[9:0]);
	assign rd_lin  = 21'(ry[9:0]) * 21'(WIDTH) + 21'(rx[9:0]);
	assign row_end  = dx_q == r_s;
	assign last_pix = row_end && (dy_q == r_s);
	assign dxstep = {{8{dx_q[9]}}, dx_q, 1'b1};
	assign dystep = {{8{dy_q[9]}}, dy_q, 1'b1};
	assign d2_n   = 18'(19'(d2_q) + dxstep);
	assign dy2_n  = 18'(19'(dy2_q) + dystep);

	assign rem_sh = {rem_q[17:0], sv_q[33:32]};
	assign trial  = {root_q[16:0], 2'b01};
	assign sq_ge  = rem_sh >= {1'b0, trial};
	assign rem_n  = sq_ge ? rem_sh - {1'b0, trial} : rem_sh;
	assign root_n = {root_q[15:0], sq_ge};
	assign num    = {r_q, 8'b0} - root_n[15:0];

	assign dr_sh  = {drem_q, dvd_q[23]};
	assign d_ge   = dr_sh >= {1'b0, falloff_q};
	assign drem_n = d_ge ? 10'(dr_sh - {1'b0, falloff_q}) : dr_sh[9:0];
	assign quo_n  = {quo_q[22:0], d_ge};

	always_comb begin
		msb = '0;
		for (int i = 0; i < 16; i++) begin
			if (quo_n[i]) begin
				msb = 4'(i);
			end
		end
	end

	assign y_sq      = mul_p_q[61:30];
	assign lval      = {5'(5'd16 - {1'b0, m_q}), 16'b0} - {5'b0, f_q};
	assign acc_cur   = (state_q == rcrs_pkg::S_EXP_ACC) ? mul_p_q[60:30] : acc_q;
	assign alpha_fin = 17'((acc_cur >> n_q) >> 14);
	assign inner     = $signed({3'b000, r_q}) - $signed({1'b0, falloff_q});
	assign inner_abs = inner[10] ? 10'(-inner) : inner[9:0];
	assign nw        = mul_p_q[23:16];
	assign r_sat     = (10'(cmd.radius) > 10'(MAX_RADIUS)) ? 8'(MAX_RADIUS) : cmd.radius;
	assign fo        = mul_p_q[17:8];

	always_comb begin
		clr_word = ram_rdata;
		clr_word[8*lane_q +: 8] = cval_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rcrs_pkg::S_INIT: begin
				if (cnt_q == LAST) state_d = rcrs_pkg::S_IDLE;
			end
			rcrs_pkg::S_IDLE: begin
				if (accept) begin
					case (cmd.operation)
						rcrs_pkg::OP_CLEAR: state_d = rcrs_pkg::S_CLR_RD;
						rcrs_pkg::OP_READ:  state_d = rcrs_pkg::S_RD;
						default:            state_d = rcrs_pkg::S_G0;
					endcase
				end
			end
			rcrs_pkg::S_CLR_RD:  state_d = rcrs_pkg::S_CLR_WR;
			rcrs_pkg::S_CLR_WR: begin
				state_d = (cnt_q == LAST) ? rcrs_pkg::S_FIN : rcrs_pkg::S_CLR_RD;
			end
			rcrs_pkg::S_RD:      state_d = rd_in ? rcrs_pkg::S_RD_WAIT : rcrs_pkg::S_FIN;
			rcrs_pkg::S_RD_WAIT: state_d = rcrs_pkg::S_FIN;
			rcrs_pkg::S_FIN: begin
				if (fin_go) state_d = rcrs_pkg::S_IDLE;
			end
			rcrs_pkg::S_G0: state_d = rcrs_pkg::S_G1;
			rcrs_pkg::S_G1: state_d = rcrs_pkg::S_G2;
			rcrs_pkg::S_G2: state_d = rcrs_pkg::S_G3;
			rcrs_pkg::S_G3: state_d = rcrs_pkg::S_G4;
			rcrs_pkg::S_G4: state_d = rcrs_pkg::S_PIX;
			rcrs_pkg::S_PIX: begin
				if (in_circ && in_bnd && op_q == rcrs_pkg::OP_GRAD) begin
					state_d = rcrs_pkg::S_GLOAD;
				end else if (last_pix) begin
					state_d = rcrs_pkg::S_FIN;
				end
			end
			rcrs_pkg::S_GLOAD: begin
				state_d = ({3'b000, d2_q} <= inner2_q) ? rcrs_pkg::S_BL_MUL
					: rcrs_pkg::S_SQRT;
			end
			rcrs_pkg::S_SQRT: begin
				if (it_q == 5'd16) state_d = rcrs_pkg::S_DIV;
			end
			rcrs_pkg::S_DIV: begin
				if (it_q == 5'd23) begin
					if (quo_n >= 24'h010000 || quo_n == '0) begin
						state_d = rcrs_pkg::S_BL_MUL;
					end else begin
						state_d = rcrs_pkg::S_LOG_MUL;
					end
				end
			end
			rcrs_pkg::S_LOG_MUL: state_d = rcrs_pkg::S_LOG_UPD;
			rcrs_pkg::S_LOG_UPD: begin
				state_d = (it_q == 5'd15) ? rcrs_pkg::S_EXP_MUL : rcrs_pkg::S_LOG_MUL;
			end
			rcrs_pkg::S_EXP_MUL: state_d = rcrs_pkg::S_EXP_SPLIT;
			rcrs_pkg::S_EXP_SPLIT: begin
				state_d = (mul_p_q[63:24] >= 40'd17) ? rcrs_pkg::S_BL_MUL
					: rcrs_pkg::S_EXP_CHK;
			end
			rcrs_pkg::S_EXP_CHK: begin
				if (f_q[15]) begin
					state_d = rcrs_pkg::S_EXP_ACC;
				end else if (it_q == 5'd16) begin
					state_d = rcrs_pkg::S_BL_MUL;
				end
			end
			rcrs_pkg::S_EXP_ACC: begin
				state_d = (it_q == 5'd16) ? rcrs_pkg::S_BL_MUL : rcrs_pkg::S_EXP_CHK;
			end
			rcrs_pkg::S_BL_MUL: state_d = rcrs_pkg::S_BL_UPD;
			rcrs_pkg::S_BL_UPD: begin
				state_d = (bl_q == 2'd3) ? rcrs_pkg::S_WR : rcrs_pkg::S_BL_MUL;
			end
			rcrs_pkg::S_WR: state_d = last_pix ? rcrs_pkg::S_FIN : rcrs_pkg::S_PIX;
			default: state_d = rcrs_pkg::S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		cmd.ready = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = cnt_q;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			rcrs_pkg::S_INIT: begin
				ram_we = 1'b1;
			end
			rcrs_pkg::S_IDLE: begin
				cmd.ready = 1'b1;
			end
			rcrs_pkg::S_CLR_RD: begin
				ram_re = 1'b1;
			end
			rcrs_pkg::S_CLR_WR: begin
				ram_we    = 1'b1;
				ram_wdata = clr_word;
			end
			rcrs_pkg::S_RD: begin
				ram_re    = rd_in;
				ram_raddr = rd_lin[AW-1:0];
			end
			rcrs_pkg::S_G0: begin
				mul_a = 32'(r_q);
				mul_b = 32'(r_q);
			end
			rcrs_pkg::S_G1: begin
				mul_a = 32'(r_q);
				mul_b = 32'(ratio_q);
			end
			rcrs_pkg::S_G3: begin
				mul_a = 32'(inner_abs);
				mul_b = 32'(inner_abs);
			end
			rcrs_pkg::S_PIX: begin
				ram_waddr = pix_lin[AW-1:0];
				ram_raddr = pix_lin[AW-1:0];
				ram_wdata = col_q;
				if (in_circ && in_bnd) begin
					if (op_q == rcrs_pkg::OP_GRAD) ram_re = 1'b1;
					else ram_we = 1'b1;
				end
			end
			rcrs_pkg::S_LOG_MUL: begin
				mul_a = 32'(x_q);
				mul_b = 32'(x_q);
			end
			rcrs_pkg::S_EXP_MUL: begin
				mul_a = 32'(lval);
				mul_b = 32'(power_q);
			end
			rcrs_pkg::S_EXP_CHK: begin
				mul_a = 32'(acc_q);
				mul_b = 32'(rcrs_pkg::CK[it_q]);
			end
			rcrs_pkg::S_BL_MUL: begin
				mul_a = 32'(col_q[8*bl_q +: 8]);
				mul_b = 32'(alpha_q);
			end
			rcrs_pkg::S_WR: begin
				ram_we    = 1'b1;
				ram_waddr = pa_q;
				ram_wdata = wd_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_p_q <= 64'(mul_a) * 64'(mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rcrs_pkg::S_INIT;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= fin_go || (rsp_valid_q && !rsp.ready);
			case (state_q)
				rcrs_pkg::S_INIT:   cnt_q <= cnt_q + 1'b1;
				rcrs_pkg::S_IDLE:   cnt_q <= '0;
				rcrs_pkg::S_CLR_WR: cnt_q <= cnt_q + 1'b1;
				default: begin
				end
			endcase
		end
	end

	// payload and iteration registers
	always_ff @(posedge clk) begin
		if (fin_go) begin
			rsp_pix_q <= res_pix_q;
			rsp_rv_q  <= res_rv_q;
		end
		case (state_q)
			rcrs_pkg::S_IDLE: begin
				op_q      <= cmd.operation;
				cx_q      <= cmd.pos_x;
				cy_q      <= cmd.pos_y;
				r_q       <= r_sat;
				col_q     <= {cmd.alpha_in, cmd.blue_in, cmd.green_in, cmd.red_in};
				lane_q    <= cmd.channel;
				cval_q    <= cmd.clear_value;
				ratio_q   <= cmd.falloff_ratio;
				power_q   <= cmd.falloff_power;
				res_pix_q <= '0;
				res_rv_q  <= 1'b0;
			end
			rcrs_pkg::S_RD_WAIT: begin
				res_pix_q <= ram_rdata;
				res_rv_q  <= 1'b1;
			end
			rcrs_pkg::S_G1: begin
				r2_q <= mul_p_q[16:0];
			end
			rcrs_pkg::S_G2: begin
				falloff_q <= (mul_p_q[63:8] > 56'd2) ? fo : 10'd2;
			end
			rcrs_pkg::S_G4: begin
				inner2_q <= mul_p_q[20:0];
				dx_q     <= -r_s;
				dy_q     <= -r_s;
				dy2_q    <= 18'(r2_q);
				d2_q     <= 18'(r2_q) + 18'(r2_q);
			end
			rcrs_pkg::S_PIX, rcrs_pkg::S_WR: begin
				pa_q <= pix_lin[AW-1:0];
				if (state_q == rcrs_pkg::S_WR || !(in_circ && in_bnd
					&& op_q == rcrs_pkg::OP_GRAD)) begin
					if (row_end) begin
						dx_q  <= -r_s;
						dy_q  <= dy_q + 10'sd1;
						dy2_q <= dy2_n;
						d2_q  <= dy2_n + 18'(r2_q);
					end else begin
						dx_q <= dx_q + 10'sd1;
						d2_q <= d2_n;
					end
				end
			end
			rcrs_pkg::S_GLOAD: begin
				wd_q    <= ram_rdata;
				bl_q    <= '0;
				alpha_q <= rcrs_pkg::ALPHA_ONE;
				sv_q    <= {d2_q, 16'b0};
				rem_q   <= '0;
				root_q  <= '0;
				it_q    <= '0;
			end
			rcrs_pkg::S_SQRT: begin
				rem_q  <= rem_n;
				root_q <= root_n;
				sv_q   <= {sv_q[31:0], 2'b00};
				if (it_q == 5'd16) begin
					dvd_q  <= {num, 8'b0};
					drem_q <= '0;
					quo_q  <= '0;
					it_q   <= '0;
				end else begin
					it_q   <= it_q + 1'b1;
				end
			end
			rcrs_pkg::S_DIV: begin
				drem_q <= drem_n;
				quo_q  <= quo_n;
				dvd_q  <= {dvd_q[22:0], 1'b0};
				if (it_q == 5'd23) begin
					it_q <= '0;
					m_q  <= msb;
					x_q  <= 31'(quo_n[15:0]) << (5'd30 - {1'b0, msb});
					f_q  <= '0;
					if (quo_n == '0) begin
						alpha_q <= (power_q == '0) ? rcrs_pkg::ALPHA_ONE : '0;
					end
				end else begin
					it_q <= it_q + 1'b1;
				end
			end
			rcrs_pkg::S_LOG_UPD: begin
				it_q <= it_q + 1'b1;
				if (y_sq[31]) begin
					x_q <= y_sq[31:1];
					f_q <= {f_q[14:0], 1'b1};
				end else begin
					x_q <= y_sq[30:0];
					f_q <= {f_q[14:0], 1'b0};
				end
			end
			rcrs_pkg::S_EXP_SPLIT: begin
				n_q   <= mul_p_q[28:24];
				f_q   <= mul_p_q[23:8];
				acc_q <= rcrs_pkg::ACC_ONE;
				it_q  <= 5'd1;
				if (mul_p_q[63:24] >= 40'd17) alpha_q <= '0;
			end
			rcrs_pkg::S_EXP_CHK: begin
				if (!f_q[15]) begin
					f_q  <= {f_q[14:0], 1'b0};
					it_q <= it_q + 1'b1;
					if (it_q == 5'd16) alpha_q <= alpha_fin;
				end
			end
			rcrs_pkg::S_EXP_ACC: begin
				acc_q <= mul_p_q[60:30];
				f_q   <= {f_q[14:0], 1'b0};
				it_q  <= it_q + 1'b1;
				if (it_q == 5'd16) alpha_q <= alpha_fin;
			end
			rcrs_pkg::S_BL_UPD: begin
				bl_q <= bl_q + 1'b1;
				if (nw > wd_q[8*bl_q +: 8]) wd_q[8*bl_q +: 8] <= nw;
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.red_out    = rsp_pix_q[7:0];
	assign rsp.green_out  = rsp_pix_q[15:8];
	assign rsp.blue_out   = rsp_pix_q[23:16];
	assign rsp.alpha_out  = rsp_pix_q[31:24];
	assign rsp.read_valid = rsp_rv_q;

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !cmd.ready)
		else $error("command taken while busy");

	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rcrs_pkg::S_FIN && rsp_valid_q && !rsp.ready)
		|=> state_q == rcrs_pkg::S_FIN)
		else $error("result slot overwritten");

	a_alpha_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rcrs_pkg::S_BL_MUL |-> alpha_q <= rcrs_pkg::ALPHA_ONE)
		else $error("alpha above one");

	a_zero_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_rv_q) |-> rsp_pix_q == '0)
		else $error("nonzero bytes without read hit");
endmodule

// ===== tb/rcrs_tb_if.sv =====
// ----------------------------------------------------------------------------
// rcrs_tb_if
// command and result item types shared by the stimulus tasks and the pixel predictor
// ----------------------------------------------------------------------------
package rcrs_tb_pkg;

	typedef struct {
		rcrs_pkg::op_t      op;
		logic signed [10:0] x;
		logic signed [10:0] y;
		logic        [7:0]  r;
		logic        [7:0]  col [4];
		logic        [1:0]  lane;
		logic        [7:0]  cval;
		logic        [9:0]  ratio;
		logic        [11:0] power;
	} cmd_item_t;

	typedef struct {
		logic [7:0] px [4];
		logic       hit;
	} pixel_rsp_t;
endpackage

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// checks the circle raster store: clears, solid and soft circles, pixel reads
// ----------------------------------------------------------------------------
// Every accepted command is applied to a local copy of the frame store and its
// result item is queued; each result from the block is compared field by field
// with the oldest queued one. Directed commands cover the edges of the store,
// the soft edge cases and both lane clears; random commands then draw small
// circles and read back pixels around them, under several idle patterns.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int W = 256;
	localparam int H = 256;
	localparam int IDLE_LIMIT = 1000000;

	logic clk;
	logic arst_n;

	rcrs_cmd_if cmd ();
	rcrs_rsp_if rsp ();

	rgba_circle_raster_store dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	logic [31:0]              frame [W*H];
	rcrs_tb_pkg::pixel_rsp_t  pending_rsp [$];
	int           errors;
	int           src_idle_pct;
	int           snk_stall_pct;
	bit           rsp_hold;
	int           quiet_cycles;
	int           last_x;
	int           last_y;
	int           last_r;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// own integer square root, floor
	function automatic longint unsigned root_floor(input longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint unsigned neg_log2(input int unsigned t);
		int m;
		longint unsigned x;
		longint unsigned f;
		m = 15;
		while (m > 0 && t[m] == 1'b0)
			m--;
		x = longint'(t) << (30 - m);
		f = 0;
		for (int i = 0; i < 16; i++) begin
			x = (x * x) >> 30;
			if (x >= (64'd1 << 31)) begin
				x = x >> 1;
				f = f | (64'd1 << (15 - i));
			end
		end
		return longint'(16 - m) * 65536 - f;
	endfunction

	function automatic int unsigned edge_alpha(input int unsigned t, input int unsigned pw);
		longint unsigned e;
		longint unsigned n;
		longint unsigned f;
		longint unsigned acc;
		if (t >= 65536)
			return 65536;
		if (t == 0)
			return (pw == 0) ? 65536 : 0;
		e = (neg_log2(t) * pw) >> 8;
		n = e >> 16;
		f = e & 64'hFFFF;
		if (n >= 17)
			return 0;
		acc = 64'd1 << 30;
		for (int k = 1; k <= 16; k++)
			if (f[16-k])
				acc = (acc * longint'(rcrs_pkg::CK[k])) >> 30;
		return int'((acc >> n) >> 14);
	endfunction

	task automatic paint_circle(input rcrs_tb_pkg::cmd_item_t c);
		int cx, cy, r, fo, falloff, inner, inner2, d2, nx, ny;
		int unsigned a, nw;
		longint unsigned s, num, t;
		logic [31:0] v;
		cx = c.x;
		cy = c.y;
		r = c.r;
		falloff = 2;
		fo = (r * int'(c.ratio)) >> 8;
		if (fo > falloff)
			falloff = fo;
		inner = r - falloff;
		inner2 = inner * inner;
		for (int dy = -r; dy <= r; dy++) begin
			for (int dx = -r; dx <= r; dx++) begin
				d2 = dx * dx + dy * dy;
				nx = cx + dx;
				ny = cy + dy;
				if (d2 > r * r || nx < 0 || nx >= W || ny < 0 || ny >= H)
					continue;
				if (c.op == rcrs_pkg::OP_SOLID) begin
					frame[ny*W+nx] = {c.col[3], c.col[2], c.col[1], c.col[0]};
					continue;
				end
				a = 65536;
				if (d2 > inner2) begin
					s = root_floor(longint'(d2) << 16);
					num = longint'(r) * 256 - s;
					t = (num * 256) / falloff;
					if (t > 65536)
						t = 65536;
					a = edge_alpha(int'(t), c.power);
				end
				v = frame[ny*W+nx];
				for (int k = 0; k < 4; k++) begin
					nw = (int'(c.col[k]) * a) >> 16;
					if (nw > v[8*k +: 8])
						v[8*k +: 8] = nw[7:0];
				end
				frame[ny*W+nx] = v;
			end
		end
	endtask

	task automatic apply_cmd(input rcrs_tb_pkg::cmd_item_t c);
		rcrs_tb_pkg::pixel_rsp_t e;
		int px, py;
		logic [31:0] v;
		e.px = '{default: 8'd0};
		e.hit = 1'b0;
		case (c.op)
			rcrs_pkg::OP_CLEAR: begin
				for (int i = 0; i < W*H; i++)
					frame[i][8*c.lane +: 8] = c.cval;
			end
			rcrs_pkg::OP_SOLID, rcrs_pkg::OP_GRAD: begin
				paint_circle(c);
			end
			rcrs_pkg::OP_READ: begin
				px = c.x;
				py = c.y;
				if (px >= 0 && px < W && py >= 0 && py < H) begin
					v = frame[py*W+px];
					for (int k = 0; k < 4; k++)
						e.px[k] = v[8*k +: 8];
					e.hit = 1'b1;
				end
			end
			default: begin
			end
		endcase
		pending_rsp.push_back(e);
	endtask

	task automatic send_cmd(input rcrs_tb_pkg::cmd_item_t c);
		if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < src_idle_pct)
				@(posedge clk);
		end
		cmd.valid         <= 1'b1;
		cmd.operation     <= c.op;
		cmd.pos_x         <= c.x;
		cmd.pos_y         <= c.y;
		cmd.radius        <= c.r;
		cmd.red_in        <= c.col[0];
		cmd.green_in      <= c.col[1];
		cmd.blue_in       <= c.col[2];
		cmd.alpha_in      <= c.col[3];
		cmd.channel       <= c.lane;
		cmd.clear_value   <= c.cval;
		cmd.falloff_ratio <= c.ratio;
		cmd.falloff_power <= c.power;
		do
			@(posedge clk);
		while (!cmd.ready);
		apply_cmd(c);
	endtask

	function automatic rcrs_tb_pkg::cmd_item_t make_cmd(input rcrs_pkg::op_t op,
		input int x, input int y, input int r);
		rcrs_tb_pkg::cmd_item_t c;
		c.op = op;
		c.x = x[10:0];
		c.y = y[10:0];
		c.r = r[7:0];
		for (int k = 0; k < 4; k++)
			c.col[k] = 8'($urandom_range(255));
		c.lane = 2'($urandom_range(3));
		c.cval = 8'($urandom_range(255));
		c.ratio = 10'($urandom_range(1023));
		c.power = 12'($urandom_range(4095));
		return c;
	endfunction

	function automatic rcrs_tb_pkg::cmd_item_t random_cmd();
		rcrs_tb_pkg::cmd_item_t c;
		int sel, x, y, r;
		sel = $urandom_range(99);
		if (sel < 50) begin
			sel = $urandom_range(99);
			if (sel < 70) begin
				x = last_x + $urandom_range(2 * last_r + 4) - last_r - 2;
				y = last_y + $urandom_range(2 * last_r + 4) - last_r - 2;
			end else if (sel < 85) begin
				x = $urandom_range(W - 1);
				y = $urandom_range(H - 1);
			end else begin
				x = $urandom_range(2047) - 1024;
				y = $urandom_range(2047) - 1024;
			end
			return make_cmd(rcrs_pkg::OP_READ, x, y, $urandom_range(255));
		end
		if ($urandom_range(19) == 0) begin
			x = $urandom_range(2047) - 1024;
			y = $urandom_range(2047) - 1024;
		end else begin
			x = $urandom_range(W + 40) - 20;
			y = $urandom_range(H + 40) - 20;
		end
		if (sel < 78) begin
			r = $urandom_range(12);
			c = make_cmd(rcrs_pkg::OP_SOLID, x, y, r);
		end else begin
			r = $urandom_range(3);
			c = make_cmd(rcrs_pkg::OP_GRAD, x, y, r);
			if ($urandom_range(3) == 0)
				c.power = $urandom_range(1) ? 12'd0 : 12'd256;
		end
		last_x = x;
		last_y = y;
		last_r = r;
		return c;
	endfunction

	task automatic wait_drained();
		cmd.valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		rcrs_tb_pkg::cmd_item_t c;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		send_cmd(make_cmd(rcrs_pkg::OP_READ, 0, 0, 0));
		send_cmd(make_cmd(rcrs_pkg::OP_READ, -1, 0, 0));
		send_cmd(make_cmd(rcrs_pkg::OP_READ, 256, 5, 0));
		send_cmd(make_cmd(rcrs_pkg::OP_READ, 5, -1024, 0));
		send_cmd(make_cmd(rcrs_pkg::OP_READ, 1023, 1023, 255));
		send_cmd(make_cmd(rcrs_pkg::OP_SOLID, 10, 10, 0));
		send_cmd(make_cmd(rcrs_pkg::OP_READ, 10, 10, 0));
		send_cmd(make_cmd(rcrs_pkg::OP_SOLID, 128, 128, 255));
		send_cmd(make_cmd(rcrs_pkg::OP_READ, 0, 0, 0));
		send_cmd(make_cmd(rcrs_pkg::OP_READ, 255, 255, 0));
		c = make_cmd(rcrs_pkg::OP_CLEAR, 0, 0, 0);
		c.lane = 2'd1;
		c.cval = 8'hFF;
		send_cmd(c);
		c.lane = 2'd2;
		c.cval = 8'h00;
		send_cmd(c);
		send_cmd(make_cmd(rcrs_pkg::OP_READ, 3, 7, 0));
		send_cmd(make_cmd(rcrs_pkg::OP_SOLID, -5, 250, 8));
		send_cmd(make_cmd(rcrs_pkg::OP_SOLID, -1024, 1023, 20));
		send_cmd(make_cmd(rcrs_pkg::OP_READ, 0, 250, 0));
		// wide flat centre, two pixel soft edge
		c = make_cmd(rcrs_pkg::OP_GRAD, 60, 60, 40);
		c.ratio = 10'd0;
		c.power = 12'd256;
		c.col = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_cmd(c);
		send_cmd(make_cmd(rcrs_pkg::OP_READ, 60, 60, 0));
		send_cmd(make_cmd(rcrs_pkg::OP_READ, 60, 99, 0));
		send_cmd(make_cmd(rcrs_pkg::OP_READ, 60, 100, 0));
		// edge wider than the radius, zero power
		c = make_cmd(rcrs_pkg::OP_GRAD, 200, 30, 3);
		c.ratio = 10'd1023;
		c.power = 12'd0;
		send_cmd(c);
		// steep power, alpha underflows
		c = make_cmd(rcrs_pkg::OP_GRAD, 200, 40, 6);
		c.ratio = 10'd512;
		c.power = 12'd4095;
		send_cmd(c);
		send_cmd(make_cmd(rcrs_pkg::OP_READ, 200, 30, 0));
		send_cmd(make_cmd(rcrs_pkg::OP_READ, 203, 30, 0));
		send_cmd(make_cmd(rcrs_pkg::OP_READ, 201, 41, 0));
		last_x = 200;
		last_y = 40;
		last_r = 6;
	endtask

	task automatic test_random(input int n, input int src_pct, input int snk_pct);
		src_idle_pct = src_pct;
		snk_stall_pct = snk_pct;
		for (int i = 0; i < n; i++)
			send_cmd(random_cmd());
	endtask

	task automatic test_backpressure();
		src_idle_pct = 0;
		snk_stall_pct = 0;
		fork
			begin
				rsp_hold = 1'b1;
				repeat (3000) @(posedge clk);
				rsp_hold = 1'b0;
			end
		join_none
		for (int i = 0; i < 20; i++)
			send_cmd(random_cmd());
	endtask

	task automatic test_drain_pause();
		src_idle_pct = 10;
		snk_stall_pct = 10;
		for (int i = 0; i < 10; i++)
			send_cmd(random_cmd());
		wait_drained();
		for (int i = 0; i < 10; i++)
			send_cmd(random_cmd());
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= !rsp_hold && ($urandom_range(99) >= snk_stall_pct);
		end
	end

	always @(posedge clk) begin
		rcrs_tb_pkg::pixel_rsp_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_rsp.size() == 0) begin
				$error("result item with nothing expected");
				errors++;
			end else begin
				e = pending_rsp.pop_front();
				if (rsp.red_out !== e.px[0]) begin
					$error("red_out exp %0d got %0d", e.px[0], rsp.red_out);
					errors++;
				end
				if (rsp.green_out !== e.px[1]) begin
					$error("green_out exp %0d got %0d", e.px[1], rsp.green_out);
					errors++;
				end
				if (rsp.blue_out !== e.px[2]) begin
					$error("blue_out exp %0d got %0d", e.px[2], rsp.blue_out);
					errors++;
				end
				if (rsp.alpha_out !== e.px[3]) begin
					$error("alpha_out exp %0d got %0d", e.px[3], rsp.alpha_out);
					errors++;
				end
				if (rsp.read_valid !== e.hit) begin
					$error("read_valid exp %0b got %0b", e.hit, rsp.read_valid);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("tb failed");
				$finish;
			end
		end
	end

	initial begin
		errors = 0;
		quiet_cycles = 0;
		rsp_hold = 1'b0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		last_x = 128;
		last_y = 128;
		last_r = 4;
		for (int i = 0; i < W*H; i++)
			frame[i] = '0;
		arst_n = 1'b0;
		cmd.valid <= 1'b0;
		cmd.operation <= rcrs_pkg::OP_READ;
		cmd.pos_x <= '0;
		cmd.pos_y <= '0;
		cmd.radius <= '0;
		cmd.red_in <= '0;
		cmd.green_in <= '0;
		cmd.blue_in <= '0;
		cmd.alpha_in <= '0;
		cmd.channel <= '0;
		cmd.clear_value <= '0;
		cmd.falloff_ratio <= '0;
		cmd.falloff_power <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(150, 0, 0);
		test_random(130, 83, 0);
		test_random(130, 0, 83);
		test_random(110, 33, 33);
		test_backpressure();
		test_drain_pause();
		src_idle_pct = 0;
		snk_stall_pct = 0;
		wait_drained();
		repeat (200) @(posedge clk);
		if (errors == 0 && pending_rsp.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
